// ===== src/glu_pkg.sv =====
// Shared widths, queue depth and item types of the GCD/LCM unit.
`default_nettype none

package glu_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int OPER_WIDTH  = DATA_WIDTH - 1;
    localparam int LCM_WIDTH   = 2 * OPER_WIDTH;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] first_value;
        logic signed [DATA_WIDTH-1:0] second_value;
    } glu_in_t;

    typedef struct packed {
        logic [OPER_WIDTH-1:0] gcd_value;
        logic [LCM_WIDTH-1:0]  lcm_value;
        logic                  bad_operand;
    } glu_out_t;

    // classified item waiting for the back end
    typedef struct packed {
        logic                  bad;
        logic [OPER_WIDTH-1:0] a;
        logic [OPER_WIDTH-1:0] b;
    } glu_job_t;

endpackage

`default_nettype wire

// ===== src/gcd_lcm_unit.sv =====
// Top level of the GCD/LCM unit: front end, item queue and arithmetic back end.
//
// Each item carries two signed 32-bit operands and yields one result: their
// greatest common divisor and their least common multiple (62 bits, no
// overflow). An item with a zero or negative operand yields bad_operand = 1
// and zero results. The back end works on one item at a time; the gcd comes
// from a binary GCD loop (one halving or subtract-and-halve per cycle), the
// lcm from a bit-serial divide of the first operand by the gcd and one 31x31
// multiply. A two-item queue lets new items be taken while the back end is
// busy, and the result register holds a finished item while the back end
// starts on the next one.
`default_nettype none

module gcd_lcm_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire glu_pkg::glu_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output glu_pkg::glu_out_t      out_data
);
    import glu_pkg::*;

    logic     job_valid;
    logic     job_ready;
    glu_job_t job;

    glu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    glu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== src/glu_front.sv =====
// Front end: accepts input items, flags bad operands and queues them.
`default_nettype none

module glu_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire glu_pkg::glu_in_t  in_data,
    output logic                   job_valid,
    input  wire logic              job_ready,
    output glu_pkg::glu_job_t      job
);
    import glu_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    glu_job_t           queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    glu_job_t           entry;
    logic               push;
    logic               pop;

    always_comb
    begin
        entry.bad = in_data.first_value[DATA_WIDTH-1] || (in_data.first_value == '0)
                 || in_data.second_value[DATA_WIDTH-1] || (in_data.second_value == '0);
        entry.a   = in_data.first_value[OPER_WIDTH-1:0];
        entry.b   = in_data.second_value[OPER_WIDTH-1:0];
    end

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign job_valid = (count_reg != '0);
    assign job       = queue_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = job_valid && job_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> count_reg == CNT_W'($past(count_reg) - 1'b1))
        else $error("queue count did not shrink on pop");

endmodule

`default_nettype wire

// ===== src/glu_back.sv =====
// Back end: binary GCD loop, bit-serial divide, multiply and result register.
`default_nettype none

module glu_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              job_valid,
    output logic                   job_ready,
    input  wire glu_pkg::glu_job_t job,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output glu_pkg::glu_out_t      out_data
);
    import glu_pkg::*;

    localparam int KW    = $clog2(OPER_WIDTH);
    localparam int CNT_W = $clog2(OPER_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_DIV,
        S_MUL,
        S_DONE
    } state_t;

    state_t                 state_reg;
    logic [OPER_WIDTH-1:0]  u_reg;
    logic [OPER_WIDTH-1:0]  v_reg;
    logic [OPER_WIDTH-1:0]  b_reg;
    logic [OPER_WIDTH-1:0]  g_reg;
    logic [OPER_WIDTH-1:0]  q_reg;
    logic [OPER_WIDTH-1:0]  rem_reg;
    logic [LCM_WIDTH-1:0]   lcm_reg;
    logic [KW-1:0]          k_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   bad_reg;
    logic                   out_valid_reg;
    glu_out_t               out_reg;

    logic                   gcd_done;
    logic [OPER_WIDTH-1:0]  g_found;
    logic                   u_ge_v;
    logic [OPER_WIDTH-1:0]  u_minus_v;
    logic [OPER_WIDTH-1:0]  v_minus_u;
    logic [OPER_WIDTH:0]    rem_shift;
    logic [OPER_WIDTH:0]    rem_sub;
    logic                   rem_ge;

    always_comb
    begin
        gcd_done  = (u_reg == '0) || (v_reg == '0);
        g_found   = OPER_WIDTH'((u_reg | v_reg) << k_reg);
        u_ge_v    = (u_reg >= v_reg);
        u_minus_v = u_reg - v_reg;
        v_minus_u = v_reg - u_reg;
        rem_shift = {rem_reg, q_reg[OPER_WIDTH-1]};
        rem_ge    = (rem_shift >= {1'b0, g_reg});
        rem_sub   = rem_shift - {1'b0, g_reg};
    end

    assign job_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        u_reg     <= job.a;
                        v_reg     <= job.b;
                        q_reg     <= job.a;
                        b_reg     <= job.b;
                        k_reg     <= '0;
                        bad_reg   <= job.bad;
                        g_reg     <= '0;
                        lcm_reg   <= '0;
                        state_reg <= job.bad ? S_DONE : S_GCD;
                    end
                end
                S_GCD:
                begin
                    priority if (gcd_done)
                    begin
                        g_reg     <= g_found;
                        rem_reg   <= '0;
                        cnt_reg   <= CNT_W'(OPER_WIDTH - 1);
                        state_reg <= S_DIV;
                    end
                    else if (!u_reg[0] && !v_reg[0])
                    begin
                        u_reg <= u_reg >> 1;
                        v_reg <= v_reg >> 1;
                        k_reg <= k_reg + 1'b1;
                    end
                    else if (!u_reg[0])
                    begin
                        u_reg <= u_reg >> 1;
                    end
                    else if (!v_reg[0])
                    begin
                        v_reg <= v_reg >> 1;
                    end
                    else if (u_ge_v)
                    begin
                        u_reg <= u_minus_v >> 1;
                    end
                    else
                    begin
                        v_reg <= v_minus_u >> 1;
                    end
                end
                S_DIV:
                begin
                    // restoring divide of a by the gcd, one quotient bit a cycle
                    rem_reg <= rem_ge ? rem_sub[OPER_WIDTH-1:0] : rem_shift[OPER_WIDTH-1:0];
                    q_reg   <= {q_reg[OPER_WIDTH-2:0], rem_ge};
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                S_MUL:
                begin
                    lcm_reg   <= LCM_WIDTH'(q_reg) * LCM_WIDTH'(b_reg);
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg.gcd_value   <= g_reg;
                        out_reg.lcm_value   <= lcm_reg;
                        out_reg.bad_operand <= bad_reg;
                        out_valid_reg       <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_gcd_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_GCD |-> (u_reg != '0 || v_reg != '0))
        else $error("gcd loop lost both operands");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < g_reg)
        else $error("partial remainder not below divisor");

    a_bad_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.bad_operand |->
            (out_reg.gcd_value == '0 && out_reg.lcm_value == '0))
        else $error("bad item with nonzero result");

    a_good_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.bad_operand |-> out_reg.gcd_value != '0)
        else $error("zero gcd on a good item");

endmodule

`default_nettype wire

// ===== dv/gcd_lcm_unit_test.sv =====
// Self-checking testbench for gcd_lcm_unit: directed and random operand pairs, checked in order.
`default_nettype none

module gcd_lcm_unit_test;

    import glu_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int RANDOM_ITEMS   = 1150;
    localparam int STEADY_FIRST   = 500;
    localparam int STEADY_LAST    = 760;
    localparam int IDLE_PERCENT   = 18;

    class gcd_lcm_ledger;
        glu_out_t due_results[$];
        int       mismatches;

        function glu_out_t gcd_lcm_of(glu_in_t item);
            logic [DATA_WIDTH-1:0] a_raw;
            logic [DATA_WIDTH-1:0] b_raw;
            logic [63:0]           x;
            logic [63:0]           y;
            logic [63:0]           r;
            logic [63:0]           lcm;
            glu_out_t              res;
            res   = '0;
            a_raw = item.first_value;
            b_raw = item.second_value;
            if (a_raw == '0 || b_raw == '0 || a_raw[DATA_WIDTH-1] || b_raw[DATA_WIDTH-1])
            begin
                res.bad_operand = 1'b1;
                return res;
            end
            x = 64'(a_raw);
            y = 64'(b_raw);
            while (y != 0)
            begin
                r = x % y;
                x = y;
                y = r;
            end
            lcm = (64'(a_raw) / x) * 64'(b_raw);
            res.gcd_value = x[OPER_WIDTH-1:0];
            res.lcm_value = lcm[LCM_WIDTH-1:0];
            return res;
        endfunction

        function void note_operands(glu_in_t item);
            due_results.push_back(gcd_lcm_of(item));
        endfunction

        function void check_result(glu_out_t got);
            glu_out_t want;
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no item outstanding: gcd %0d lcm %0d bad %0b",
                             got.gcd_value, got.lcm_value, got.bad_operand);
                return;
            end
            want = due_results.pop_front();
            if (got.gcd_value !== want.gcd_value || got.lcm_value !== want.lcm_value ||
                got.bad_operand !== want.bad_operand)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected gcd %0d lcm %0d bad %0b, got gcd %0d lcm %0d bad %0b",
                             want.gcd_value, want.lcm_value, want.bad_operand,
                             got.gcd_value, got.lcm_value, got.bad_operand);
            end
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    glu_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    glu_out_t out_data;

    logic     steady = 1'b0;
    int       quiet_cycles = 0;

    gcd_lcm_ledger ledger = new();

    gcd_lcm_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #10 clk = ~clk;

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_ready <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // sampled values are those held across the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                ledger.note_operands(in_data);
            if (out_valid && out_ready)
                ledger.check_result(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic send_pair(input logic [DATA_WIDTH-1:0] a, input logic [DATA_WIDTH-1:0] b);
        int gap;
        in_valid              <= 1'b1;
        in_data.first_value   <= a;
        in_data.second_value  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        if (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [DATA_WIDTH-1:0] positive_operand(int unsigned bits);
        logic [DATA_WIDTH-1:0] v;
        v = $urandom;
        v = v >> (DATA_WIDTH - bits);
        v[DATA_WIDTH-1] = 1'b0;
        if (v == '0)
            v = 1;
        return v;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] faulty_operand();
        logic [DATA_WIDTH-1:0] v;
        v = $urandom;
        v[DATA_WIDTH-1] = 1'b1;
        if ($urandom_range(0, 1) == 0)
            v = '0;
        return v;
    endfunction

    task automatic send_random_pair();
        logic [DATA_WIDTH-1:0] a;
        logic [DATA_WIDTH-1:0] b;
        logic [DATA_WIDTH-1:0] g;
        int unsigned           mode;
        int unsigned           gw;
        mode = $urandom_range(0, 99);
        if (mode < 15)
        begin
            a = positive_operand($urandom_range(1, 31));
            b = positive_operand($urandom_range(1, 31));
            case ($urandom_range(0, 2))
                0: a = faulty_operand();
                1: b = faulty_operand();
                default:
                begin
                    a = faulty_operand();
                    b = faulty_operand();
                end
            endcase
        end
        else if (mode < 50)
        begin
            // shared factor, product kept below the sign bit
            gw = $urandom_range(1, 16);
            g  = positive_operand(gw);
            a  = g * positive_operand($urandom_range(1, 31 - gw));
            b  = g * positive_operand($urandom_range(1, 31 - gw));
        end
        else if (mode < 58)
        begin
            a = positive_operand($urandom_range(1, 31));
            b = ($urandom_range(0, 1) == 0) ? a : 1;
        end
        else
        begin
            a = positive_operand($urandom_range(1, 31));
            b = positive_operand($urandom_range(1, 31));
        end
        send_pair(a, b);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pair(32'd1, 32'd1);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFE);
        send_pair(32'h7FFF_FFFF, 32'd1);
        send_pair(32'd1, 32'h7FFF_FFFF);
        send_pair(32'd2147483647, 32'd2147483629);
        send_pair(32'd1836311903, 32'd1134903170);
        send_pair(32'd12, 32'd18);
        send_pair(32'd18, 32'd12);
        send_pair(32'h4000_0000, 32'h0010_0000);
        send_pair(32'h5555_5555, 32'h2AAA_AAAA);
        send_pair(32'h2AAA_AAAA, 32'h5555_5555);
        send_pair(32'd0, 32'd5);
        send_pair(32'd5, 32'd0);
        send_pair(32'd0, 32'd0);
        send_pair(32'hFFFF_FFFF, 32'd5);
        send_pair(32'd5, 32'hFFFF_FFFF);
        send_pair(32'h8000_0000, 32'd7);
        send_pair(32'd7, 32'h8000_0000);
        send_pair(32'h8000_0000, 32'h8000_0000);
        send_pair(32'hAAAA_AAAA, 32'h5555_5555);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            steady <= (i >= STEADY_FIRST && i < STEADY_LAST);
            send_random_pair();
        end
        steady   <= 1'b0;
        in_valid <= 1'b0;

        while (ledger.due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (ledger.mismatches == 0 && ledger.due_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/glu_pkg.sv
src/glu_front.sv
src/glu_back.sv
src/gcd_lcm_unit.sv
dv/gcd_lcm_unit_test.sv
